>>> hw/rtl/wsm_pkg.sv
package wsm_pkg;

    localparam int CMD_W    = 16;
    localparam int SPEED_W  = 16;
    localparam int WHEELS   = 4;
    localparam int SUM_W    = 42;
    localparam int MAG_W    = SUM_W - 1;
    localparam int QUO_W    = 16;
    localparam int PROD_W   = MAG_W + QUO_W;
    localparam int STEPS    = QUO_W;
    localparam int FRAC_W   = 16;

    // sqrt(3)/2 in Q1.16
    localparam logic signed [17:0] K_Q16 = 18'sd56756;

    localparam logic [2:0] MODE_DIFF    = 3'd0;
    localparam logic [2:0] MODE_SKID    = 3'd1;
    localparam logic [2:0] MODE_OMNI90  = 3'd2;
    localparam logic [2:0] MODE_MECANUM = 3'd3;
    localparam logic [2:0] MODE_OMNI3   = 3'd4;
    localparam logic [2:0] MODE_HOLD    = 3'd5;
    localparam logic [2:0] MODE_DEBUG   = 3'd6;
    localparam logic [2:0] MODE_HOLD_B  = 3'd7;

    localparam logic [2:0] REG_DRIVE_MODE    = 3'd0;
    localparam logic [2:0] REG_SPEED_LIMIT   = 3'd1;
    localparam logic [2:0] REG_YAW_GAIN      = 3'd2;
    localparam logic [2:0] REG_MOTOR_PRESENT = 3'd3;
    localparam logic [2:0] REG_REVERSE_MASK  = 3'd4;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    // signed saturation of a sign and magnitude pair
    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic neg,
                                                            input logic [QUO_W-1:0] m);
        logic signed [SPEED_W-1:0] r;
        if (neg) begin
            if (m >= QUO_W'(SPEED_MAX) + QUO_W'(1)) r = SPEED_MIN;
            else                                    r = -$signed(SPEED_W'(m));
        end
        else begin
            if (m > QUO_W'(SPEED_MAX)) r = SPEED_MAX;
            else                       r = $signed(SPEED_W'(m));
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/wsm_divider.sv
module wsm_divider
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [wsm_pkg::PROD_W-1:0]  num,
    input  logic [wsm_pkg::MAG_W-1:0]   den,
    output logic [wsm_pkg::QUO_W-1:0]   quo
);

    logic [wsm_pkg::PROD_W-1:0] rem_reg [0:wsm_pkg::STEPS];
    logic [wsm_pkg::MAG_W-1:0]  den_reg [0:wsm_pkg::STEPS];
    logic [wsm_pkg::QUO_W-1:0]  quo_reg [0:wsm_pkg::STEPS];
    logic [wsm_pkg::PROD_W-1:0] rem_next [0:wsm_pkg::STEPS-1];
    logic [wsm_pkg::QUO_W-1:0]  quo_next [0:wsm_pkg::STEPS-1];

    // one restoring step per stage, msb first
    for (genvar i = 0; i < wsm_pkg::STEPS; i++) begin : g_step
        localparam int SH = wsm_pkg::STEPS - 1 - i;
        logic [wsm_pkg::PROD_W-1:0] trial;
        logic                       fit;
        assign trial       = wsm_pkg::PROD_W'(den_reg[i]) << SH;
        assign fit         = rem_reg[i] >= trial;
        assign rem_next[i] = fit ? rem_reg[i] - trial : rem_reg[i];
        assign quo_next[i] = quo_reg[i] | (wsm_pkg::QUO_W'(fit) << SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            for (int i = 0; i < wsm_pkg::STEPS; i++)
            begin
                rem_reg[i+1] <= rem_next[i];
                den_reg[i+1] <= den_reg[i];
                quo_reg[i+1] <= quo_next[i];
            end
        end
    end

    assign quo = quo_reg[wsm_pkg::STEPS];

endmodule

>>> hw/rtl/wheel_speed_mixer_unit.sv
// channel   dir   handshake              payload
// cfg       in    cfg_we                 cfg_index, cfg_data
// command   in    in_valid / in_ready    cmd_x, cmd_y, cmd_yaw
// wheels    out   out_valid / out_ready  wheel_one..wheel_four, wheel_active
//
// one request per cycle unless stalled; each request is registered through stages a to d,
// the 16-step restoring divider used for limit scaling and the output register
// reset clears config but for yaw gain (set to 1), stored wheel speeds and all stage valid bits
// stall: the whole pipeline freezes while the output register is full and not taken
// stored speeds are read and written only at the output stage, in request order
module wheel_speed_mixer_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [wsm_pkg::CMD_W-1:0]    cmd_x,
    input  logic signed [wsm_pkg::CMD_W-1:0]    cmd_y,
    input  logic signed [wsm_pkg::CMD_W-1:0]    cmd_yaw,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wsm_pkg::SPEED_W-1:0]  wheel_one,
    output logic signed [wsm_pkg::SPEED_W-1:0]  wheel_two,
    output logic signed [wsm_pkg::SPEED_W-1:0]  wheel_three,
    output logic signed [wsm_pkg::SPEED_W-1:0]  wheel_four,
    output logic [wsm_pkg::WHEELS-1:0]          wheel_active
);

    typedef struct packed {
        logic                                          scale;
        logic [2:0]                                    mode;
        logic [wsm_pkg::WHEELS-1:0]                    neg;
        logic [wsm_pkg::WHEELS-1:0][wsm_pkg::QUO_W-1:0] umag;
    } sb_t;

    // configuration
    logic [2:0]                 drive_mode_reg;
    logic [15:0]                speed_limit_reg;
    logic [7:0]                 yaw_gain_reg;
    logic [wsm_pkg::WHEELS-1:0] motor_present_reg;
    logic [wsm_pkg::WHEELS-1:0] reverse_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg    <= wsm_pkg::MODE_DIFF;
            speed_limit_reg   <= '0;
            yaw_gain_reg      <= 8'd1;
            motor_present_reg <= '0;
            reverse_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wsm_pkg::REG_DRIVE_MODE:    drive_mode_reg    <= cfg_data[2:0];
                wsm_pkg::REG_SPEED_LIMIT:   speed_limit_reg   <= cfg_data;
                wsm_pkg::REG_YAW_GAIN:      yaw_gain_reg      <= cfg_data[7:0];
                wsm_pkg::REG_MOTOR_PRESENT: motor_present_reg <= cfg_data[3:0];
                wsm_pkg::REG_REVERSE_MASK:  reverse_mask_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // global advance: everything moves when the output slot can take a value
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage a: yaw gain and sqrt(3)/2 products
    logic                              a_valid_reg;
    logic [2:0]                        a_mode_reg;
    logic signed [wsm_pkg::CMD_W-1:0]  a_x_reg, a_y_reg, a_yaw_reg;
    logic signed [24:0]                a_w_reg;
    logic signed [33:0]                a_ky_reg;

    // stage b: wide wheel sums
    logic                              b_valid_reg;
    logic [2:0]                        b_mode_reg;
    logic signed [wsm_pkg::SUM_W-1:0]  b_s_reg [wsm_pkg::WHEELS];
    logic signed [wsm_pkg::SUM_W-1:0]  b_s_next [wsm_pkg::WHEELS];

    // stage c: sign and magnitude
    logic                              c_valid_reg;
    logic [2:0]                        c_mode_reg;
    logic [wsm_pkg::WHEELS-1:0]        c_neg_reg;
    logic [wsm_pkg::MAG_W-1:0]         c_mag_reg [wsm_pkg::WHEELS];

    // stage d: largest magnitude and magnitude * limit
    logic                              d_valid_reg;
    logic [2:0]                        d_mode_reg;
    logic [wsm_pkg::WHEELS-1:0]        d_neg_reg;
    logic [wsm_pkg::MAG_W-1:0]         d_mag_reg [wsm_pkg::WHEELS];
    logic [wsm_pkg::MAG_W-1:0]         d_max_reg;
    logic [wsm_pkg::PROD_W-1:0]        d_prod_reg [wsm_pkg::WHEELS];
    logic [wsm_pkg::MAG_W-1:0]         m01, m23, max_next;

    // divider-aligned side band
    logic [wsm_pkg::STEPS:0]           sb_valid_reg;
    sb_t                               sb_reg [0:wsm_pkg::STEPS];
    sb_t                               sb_next;
    logic [wsm_pkg::MAG_W-1:0]         lim_wide;
    logic [wsm_pkg::QUO_W-1:0]         quo [wsm_pkg::WHEELS];

    // stored speeds before direction
    logic [wsm_pkg::WHEELS-1:0][wsm_pkg::SPEED_W-1:0] last_speed_reg;
    logic [wsm_pkg::WHEELS-1:0][wsm_pkg::SPEED_W-1:0] last_speed_next;
    logic [wsm_pkg::WHEELS-1:0][wsm_pkg::SPEED_W-1:0] drive_next;
    logic [wsm_pkg::WHEELS-1:0]                       active_next;
    logic [wsm_pkg::WHEELS-1:0]                       used;
    logic                                             compute;
    logic signed [wsm_pkg::SPEED_W-1:0] wheel_one_reg, wheel_two_reg;
    logic signed [wsm_pkg::SPEED_W-1:0] wheel_three_reg, wheel_four_reg;
    logic [wsm_pkg::WHEELS-1:0]         wheel_active_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            sb_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            sb_valid_reg  <= {sb_valid_reg[wsm_pkg::STEPS-1:0], d_valid_reg};
            out_valid_reg <= sb_valid_reg[wsm_pkg::STEPS];
        end
    end

    // stage a datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mode_reg <= drive_mode_reg;
            a_x_reg    <= cmd_x;
            a_y_reg    <= cmd_y;
            a_yaw_reg  <= cmd_yaw;
            a_w_reg    <= 25'(cmd_yaw) * 25'($signed({1'b0, yaw_gain_reg}));
            a_ky_reg   <= 34'(cmd_y) * 34'(wsm_pkg::K_Q16);
        end
    end

    // mixing matrix per drive mode
    always_comb
    begin
        logic signed [wsm_pkg::SUM_W-1:0] x, y, yaw, w, ky;
        x   = wsm_pkg::SUM_W'(a_x_reg);
        y   = wsm_pkg::SUM_W'(a_y_reg);
        yaw = wsm_pkg::SUM_W'(a_yaw_reg);
        w   = wsm_pkg::SUM_W'(a_w_reg);
        ky  = wsm_pkg::SUM_W'(a_ky_reg);
        for (int k = 0; k < wsm_pkg::WHEELS; k++)
        begin
            b_s_next[k] = '0;
        end
        unique case (a_mode_reg)
            wsm_pkg::MODE_DIFF:
            begin
                b_s_next[0] = y + yaw;
                b_s_next[1] = y - yaw;
            end
            wsm_pkg::MODE_SKID:
            begin
                b_s_next[0] = y + yaw;
                b_s_next[1] = y - yaw;
                b_s_next[2] = y - yaw;
                b_s_next[3] = y + yaw;
            end
            wsm_pkg::MODE_OMNI90:
            begin
                b_s_next[0] = y + w;
                b_s_next[1] = w - x;
                b_s_next[2] = w - y;
                b_s_next[3] = x + w;
            end
            wsm_pkg::MODE_MECANUM:
            begin
                b_s_next[0] = y - x + w;
                b_s_next[1] = y + x - w;
                b_s_next[2] = y - x - w;
                b_s_next[3] = y + x + w;
            end
            wsm_pkg::MODE_OMNI3:
            begin
                // q16 fixed point: x/2 is x << 15
                b_s_next[0] = (w <<< wsm_pkg::FRAC_W) - (x <<< (wsm_pkg::FRAC_W - 1)) - ky;
                b_s_next[1] = (w <<< wsm_pkg::FRAC_W) + (x <<< wsm_pkg::FRAC_W);
                b_s_next[2] = (w <<< wsm_pkg::FRAC_W) - (x <<< (wsm_pkg::FRAC_W - 1)) + ky;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_mode_reg <= a_mode_reg;
            b_s_reg    <= b_s_next;
        end
    end

    // stage c: split into sign and magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_mode_reg <= b_mode_reg;
            for (int k = 0; k < wsm_pkg::WHEELS; k++)
            begin
                c_neg_reg[k] <= b_s_reg[k][wsm_pkg::SUM_W-1];
                c_mag_reg[k] <= b_s_reg[k][wsm_pkg::SUM_W-1] ?
                                wsm_pkg::MAG_W'(-b_s_reg[k]) : wsm_pkg::MAG_W'(b_s_reg[k]);
            end
        end
    end

    // stage d: two-level max tree alongside the scaling products
    assign m01      = (c_mag_reg[0] > c_mag_reg[1]) ? c_mag_reg[0] : c_mag_reg[1];
    assign m23      = (c_mag_reg[2] > c_mag_reg[3]) ? c_mag_reg[2] : c_mag_reg[3];
    assign max_next = (m01 > m23) ? m01 : m23;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_mode_reg <= c_mode_reg;
            d_neg_reg  <= c_neg_reg;
            d_mag_reg  <= c_mag_reg;
            d_max_reg  <= max_next;
            for (int k = 0; k < wsm_pkg::WHEELS; k++)
            begin
                d_prod_reg[k] <= wsm_pkg::PROD_W'(c_mag_reg[k]) *
                                 wsm_pkg::PROD_W'(speed_limit_reg);
            end
        end
    end

    // stage e: limit test and unscaled result, clamped to the quotient width
    assign lim_wide = (d_mode_reg == wsm_pkg::MODE_OMNI3) ?
                      (wsm_pkg::MAG_W'(speed_limit_reg) << wsm_pkg::FRAC_W) :
                      wsm_pkg::MAG_W'(speed_limit_reg);

    always_comb
    begin
        logic [wsm_pkg::MAG_W-1:0] um;
        sb_next.mode  = d_mode_reg;
        sb_next.neg   = d_neg_reg;
        sb_next.scale = d_max_reg > lim_wide;
        for (int k = 0; k < wsm_pkg::WHEELS; k++)
        begin
            um = (d_mode_reg == wsm_pkg::MODE_OMNI3) ?
                 (d_mag_reg[k] >> wsm_pkg::FRAC_W) : d_mag_reg[k];
            sb_next.umag[k] = (um > wsm_pkg::MAG_W'({wsm_pkg::QUO_W{1'b1}})) ?
                              {wsm_pkg::QUO_W{1'b1}} : um[wsm_pkg::QUO_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[0] <= sb_next;
            for (int i = 0; i < wsm_pkg::STEPS; i++)
            begin
                sb_reg[i+1] <= sb_reg[i];
            end
        end
    end

    // |s| * limit / max, one lane per wheel
    for (genvar k = 0; k < wsm_pkg::WHEELS; k++) begin : g_div
        wsm_divider u_div
        (
            .clk (clk),
            .en  (adv),
            .num (d_prod_reg[k]),
            .den (d_max_reg),
            .quo (quo[k])
        );
    end

    // output stage: saturate, update stored speeds, apply direction and mask
    always_comb
    begin
        sb_t                               t;
        logic signed [wsm_pkg::SPEED_W-1:0] v;
        t       = sb_reg[wsm_pkg::STEPS];
        compute = (t.mode == wsm_pkg::MODE_DIFF)    || (t.mode == wsm_pkg::MODE_SKID)  ||
                  (t.mode == wsm_pkg::MODE_OMNI90)  || (t.mode == wsm_pkg::MODE_MECANUM) ||
                  (t.mode == wsm_pkg::MODE_OMNI3);
        unique case (t.mode)
            wsm_pkg::MODE_DIFF:  used = 4'b0011;
            wsm_pkg::MODE_OMNI3: used = 4'b0111;
            default:             used = 4'b1111;
        endcase
        active_next = motor_present_reg & used;
        for (int k = 0; k < wsm_pkg::WHEELS; k++)
        begin
            last_speed_next[k] = wsm_pkg::sat_speed(t.neg[k], t.scale ? quo[k] : t.umag[k]);
            v = compute ? $signed(last_speed_next[k]) : $signed(last_speed_reg[k]);
            if (reverse_mask_reg[k])
            begin
                v = (v == wsm_pkg::SPEED_MIN) ? wsm_pkg::SPEED_MAX : -v;
            end
            if ((t.mode == wsm_pkg::MODE_DEBUG) || !active_next[k])
            begin
                v = '0;
            end
            drive_next[k] = v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_speed_reg <= '0;
        end
        else if (adv && sb_valid_reg[wsm_pkg::STEPS] && compute)
        begin
            last_speed_reg <= last_speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && sb_valid_reg[wsm_pkg::STEPS])
        begin
            wheel_one_reg    <= $signed(drive_next[0]);
            wheel_two_reg    <= $signed(drive_next[1]);
            wheel_three_reg  <= $signed(drive_next[2]);
            wheel_four_reg   <= $signed(drive_next[3]);
            wheel_active_reg <= active_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign wheel_one    = wheel_one_reg;
    assign wheel_two    = wheel_two_reg;
    assign wheel_three  = wheel_three_reg;
    assign wheel_four   = wheel_four_reg;
    assign wheel_active = wheel_active_reg;

    // hold and debug requests leave the stored speeds alone
    a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        adv && sb_valid_reg[wsm_pkg::STEPS] && !compute |=> $stable(last_speed_reg))
        else $error("stored speeds changed on a hold or debug request");

    // a stall freezes the stage a valid bit and the last divider-aligned valid bit
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(a_valid_reg) && $stable(sb_valid_reg[wsm_pkg::STEPS]))
        else $error("pipeline moved during a stall");

    // an inactive wheel always drives zero
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (wheel_active_reg[0] || wheel_one_reg == '0) &&
                          (wheel_active_reg[1] || wheel_two_reg == '0) &&
                          (wheel_active_reg[2] || wheel_three_reg == '0) &&
                          (wheel_active_reg[3] || wheel_four_reg == '0))
        else $error("inactive wheel driven");

endmodule

>>> tb/wheel_speed_mixer_unit_tb.sv
`timescale 1ns / 100ps

module wheel_speed_mixer_unit_tb;

    typedef struct packed {
        logic signed [15:0] w1;
        logic signed [15:0] w2;
        logic signed [15:0] w3;
        logic signed [15:0] w4;
        logic [3:0]         act;
    } wheel_set_t;

    // mixing predictor with its own copy of config and stored speeds
    class wheel_scoreboard;
        logic [2:0]  mode;
        logic [15:0] limit;
        logic [7:0]  gain;
        logic [3:0]  present;
        logic [3:0]  reverse;
        longint      stored[4];
        wheel_set_t  pending[$];
        int          mismatches;

        function void clear();
            mode = wsm_pkg::MODE_DIFF;
            limit = 0;
            gain = 1;
            present = 0;
            reverse = 0;
            foreach (stored[k]) stored[k] = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                wsm_pkg::REG_DRIVE_MODE:    mode = val[2:0];
                wsm_pkg::REG_SPEED_LIMIT:   limit = val;
                wsm_pkg::REG_YAW_GAIN:      gain = val[7:0];
                wsm_pkg::REG_MOTOR_PRESENT: present = val[3:0];
                wsm_pkg::REG_REVERSE_MASK:  reverse = val[3:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        // scale against the limit, drop the fixed-point unit, store
        function void scale_and_store(longint s[4], longint unit);
            longint peak;
            longint lim;
            peak = 0;
            lim = longint'(limit) * unit;
            foreach (s[k]) if (absval(s[k]) > peak) peak = absval(s[k]);
            foreach (s[k])
                if (peak > lim) stored[k] = clamp(s[k] * longint'(limit) / peak);
                else            stored[k] = clamp(s[k] / unit);
        endfunction

        function void note_command(logic signed [15:0] cx, logic signed [15:0] cy,
                                   logic signed [15:0] cw);
            longint x, y, yaw, w, s[4], v;
            logic [3:0] used;
            logic zero;
            wheel_set_t r;
            x = cx; y = cy; yaw = cw;
            w = yaw * longint'(gain);
            used = 4'hf;
            zero = 0;
            case (mode)
                wsm_pkg::MODE_DIFF: begin
                    s = '{y + yaw, y - yaw, 0, 0};
                    scale_and_store(s, 1);
                    used = 4'h3;
                end
                wsm_pkg::MODE_SKID: begin
                    s = '{y + yaw, y - yaw, y - yaw, y + yaw};
                    scale_and_store(s, 1);
                end
                wsm_pkg::MODE_OMNI90: begin
                    s = '{y + w, -x + w, -y + w, x + w};
                    scale_and_store(s, 1);
                end
                wsm_pkg::MODE_MECANUM: begin
                    s = '{y - x + w, y + x - w, y - x - w, y + x + w};
                    scale_and_store(s, 1);
                end
                wsm_pkg::MODE_OMNI3: begin
                    s[0] = -x * 32768 - 64'sd56756 * y + w * 65536;
                    s[1] = x * 65536 + w * 65536;
                    s[2] = -x * 32768 + 64'sd56756 * y + w * 65536;
                    s[3] = 0;
                    scale_and_store(s, 65536);
                    used = 4'h7;
                end
                wsm_pkg::MODE_DEBUG: zero = 1;
                default: ;
            endcase
            r.act = present & used;
            for (int k = 0; k < 4; k++) begin
                v = stored[k];
                if (reverse[k]) v = clamp(-v);
                if (zero || !r.act[k]) v = 0;
                case (k)
                    0: r.w1 = v[15:0];
                    1: r.w2 = v[15:0];
                    2: r.w3 = v[15:0];
                    default: r.w4 = v[15:0];
                endcase
            end
            pending.push_back(r);
        endfunction

        function void check_wheels(wheel_set_t got);
            wheel_set_t exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("wheel mismatch: expected %p actual %p", exp_r, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [2:0] cfg_index = wsm_pkg::REG_DRIVE_MODE;
    logic [15:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] cmd_x = 0, cmd_y = 0, cmd_yaw = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [15:0] wheel_one, wheel_two, wheel_three, wheel_four;
    logic [3:0] wheel_active;

    wheel_speed_mixer_unit dut (.*);

    always #10 clk = ~clk;

    wheel_scoreboard board = new();
    // idling allowed only in the early part of the run
    bit idle_on = 1;
    int stall_cycles = 0;
    int accepted_cmds = 0;

    // sink: random stall bursts on the result side
    always @(negedge clk) begin
        if (!rst_n) out_ready <= 0;
        else if (stall_cycles > 0) begin
            out_ready <= 0;
            stall_cycles <= stall_cycles - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0) begin
            out_ready <= 0;
            stall_cycles <= $urandom_range(0, 2);
        end
        else out_ready <= 1;
    end

    // results are compared at the rising edge where they are taken
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_wheels('{wheel_one, wheel_two, wheel_three, wheel_four, wheel_active});
        if (rst_n && in_valid && in_ready) begin
            board.note_command(cmd_x, cmd_y, cmd_yaw);
            accepted_cmds++;
        end
    end

    // watchdog: cycles with no request or result taken
    int quiet = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 5000) begin
            $display("wheel_speed_mixer_unit_tb failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // one request; valid stays high until taken, optional gap first
    task automatic send_cmd(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] yaw);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        cmd_x <= x;
        cmd_y <= y;
        cmd_yaw <= yaw;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // drain all outstanding results before touching config
    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_setting(int mode);
        write_reg(wsm_pkg::REG_DRIVE_MODE, 16'(mode));
        case ($urandom_range(0, 4))
            0: write_reg(wsm_pkg::REG_SPEED_LIMIT, 16'h0000);
            1: write_reg(wsm_pkg::REG_SPEED_LIMIT, 16'hffff);
            2: write_reg(wsm_pkg::REG_SPEED_LIMIT, 16'($urandom_range(1, 300)));
            default: write_reg(wsm_pkg::REG_SPEED_LIMIT, 16'($urandom));
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(wsm_pkg::REG_YAW_GAIN, 16'd0);
            1: write_reg(wsm_pkg::REG_YAW_GAIN, 16'd255);
            default: write_reg(wsm_pkg::REG_YAW_GAIN, 16'($urandom_range(1, 255)));
        endcase
        write_reg(wsm_pkg::REG_MOTOR_PRESENT, 16'($urandom_range(0, 15)));
        write_reg(wsm_pkg::REG_REVERSE_MASK, 16'($urandom_range(0, 15)));
    endtask

    initial begin
        int mode;
        board.clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset config first, then extremes in every mode
        send_cmd(16'sd100, 16'sd200, -16'sd50);
        drain();
        write_reg(wsm_pkg::REG_MOTOR_PRESENT, 16'h000f);
        write_reg(wsm_pkg::REG_SPEED_LIMIT, 16'hffff);
        write_reg(wsm_pkg::REG_REVERSE_MASK, 16'h0005);
        write_reg(wsm_pkg::REG_YAW_GAIN, 16'd255);
        for (mode = 0; mode < 8; mode++) begin
            write_reg(wsm_pkg::REG_DRIVE_MODE, 16'(mode));
            send_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff);
            send_cmd(16'sh8000, 16'sh8000, 16'sh8000);
            send_cmd(16'sh8000, 16'sh7fff, -16'sd3);
            drain();
        end
        // zero limit scales any nonzero speed to zero
        write_reg(wsm_pkg::REG_SPEED_LIMIT, 16'h0000);
        write_reg(wsm_pkg::REG_DRIVE_MODE, 16'(wsm_pkg::MODE_OMNI3));
        send_cmd(16'sd1, 16'sd1, 16'sd0);
        drain();

        // random phases over varied settings, hold/debug kept after a real mode
        for (int ph = 0; ph < 55; ph++) begin
            if (ph >= 45) idle_on = 0;
            random_setting(ph < 40 && (ph % 7) >= 5 ? (ph % 7) : (ph % 5));
            if (ph % 7 == 5 || ph % 7 == 6) begin
                for (int i = 0; i < 10; i++) send_cmd(pick_val(), pick_val(), pick_val());
                drain();
                write_reg(wsm_pkg::REG_DRIVE_MODE, 16'($urandom_range(5, 7)));
            end
            for (int i = 0; i < 27; i++) send_cmd(pick_val(), pick_val(), pick_val());
            drain();
        end

        repeat (30) @(negedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("wheel_speed_mixer_unit_tb passed");
        else
            $display("wheel_speed_mixer_unit_tb failed");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/wsm_pkg.sv
hw/rtl/wsm_divider.sv
hw/rtl/wheel_speed_mixer_unit.sv
tb/wheel_speed_mixer_unit_tb.sv
